/* hw/rtl/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define AST_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define AST_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tdpt_pkg.sv */
// package: widths, control word, condition codes and microcode for the prime test
`default_nettype none
package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int PC_W        = 4;

  typedef logic [PC_W-1:0] pc_t;

  // microprogram step addresses
  localparam pc_t STEP_WAIT   = pc_t'(0);
  localparam pc_t STEP_LE1    = pc_t'(1);
  localparam pc_t STEP_LT4    = pc_t'(2);
  localparam pc_t STEP_EVEN   = pc_t'(3);
  localparam pc_t STEP_LOOP   = pc_t'(4);
  localparam pc_t STEP_DIV    = pc_t'(5);
  localparam pc_t STEP_REMZ   = pc_t'(6);
  localparam pc_t STEP_INCD   = pc_t'(7);
  localparam pc_t STEP_NOTP   = pc_t'(8);
  localparam pc_t STEP_PRIME  = pc_t'(9);
  localparam pc_t STEP_FINISH = pc_t'(10);

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_JUMP_IF,
    SEQ_JUMP_IFN
  } seq_op_t;

  typedef enum logic [2:0] {
    C_START,
    C_LE1,
    C_LT4,
    C_EVEN,
    C_SQ_GT,
    C_DIV_MORE,
    C_REM_ZERO,
    C_OUT_FREE
  } cond_sel_t;

  typedef struct packed {
    logic start;
    logic le1;
    logic lt4;
    logic even;
    logic sq_gt;
    logic div_more;
    logic rem_zero;
    logic out_free;
  } cond_t;

  typedef struct packed {
    logic      accept;
    logic      div_init;
    logic      div_step;
    logic      inc_d;
    logic      set_res;
    logic      res_val;
    logic      emit;
    seq_op_t   seq;
    cond_sel_t sel;
    pc_t       target;
  } ctl_t;

  function automatic ctl_t cw(logic acc, logic dinit, logic dstep, logic incd,
                              logic setr, logic rval, logic emit,
                              seq_op_t seq, cond_sel_t sel, pc_t target);
    ctl_t c;
    c.accept   = acc;
    c.div_init = dinit;
    c.div_step = dstep;
    c.inc_d    = incd;
    c.set_res  = setr;
    c.res_val  = rval;
    c.emit     = emit;
    c.seq      = seq;
    c.sel      = sel;
    c.target   = target;
    return c;
  endfunction

  // control store
  function automatic ctl_t ucode(pc_t pc);
    ctl_t c;
    unique case (pc)
      STEP_WAIT:   c = cw(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IFN, C_START, STEP_WAIT);
      STEP_LE1:    c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_LE1, STEP_NOTP);
      STEP_LT4:    c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_LT4, STEP_PRIME);
      STEP_EVEN:   c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_EVEN, STEP_NOTP);
      STEP_LOOP:   c = cw(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_SQ_GT, STEP_PRIME);
      STEP_DIV:    c = cw(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_DIV_MORE, STEP_DIV);
      STEP_REMZ:   c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP_IF, C_REM_ZERO, STEP_NOTP);
      STEP_INCD:   c = cw(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP, C_START, STEP_LOOP);
      STEP_NOTP:   c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                          SEQ_JUMP, C_START, STEP_FINISH);
      STEP_PRIME:  c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                          SEQ_NEXT, C_START, STEP_FINISH);
      STEP_FINISH: c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                          SEQ_JUMP, C_START, STEP_WAIT);
      default:     c = cw(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          SEQ_JUMP, C_START, STEP_WAIT);
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/tdpt_sequencer.sv */
// microprogram sequencer: step counter, control store lookup, conditional jumps
`default_nettype none
module tdpt_sequencer
  import tdpt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cond_t cond,
  output ctl_t  ctl
);

  pc_t  pc;
  pc_t  pc_next;
  logic cond_hit;
  logic taken;

  assign ctl = ucode(pc);

  always_comb begin
    unique case (ctl.sel)
      C_START:    cond_hit = cond.start;
      C_LE1:      cond_hit = cond.le1;
      C_LT4:      cond_hit = cond.lt4;
      C_EVEN:     cond_hit = cond.even;
      C_SQ_GT:    cond_hit = cond.sq_gt;
      C_DIV_MORE: cond_hit = cond.div_more;
      C_REM_ZERO: cond_hit = cond.rem_zero;
      C_OUT_FREE: cond_hit = cond.out_free;
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (ctl.seq)
      SEQ_NEXT:     taken = 1'b0;
      SEQ_JUMP:     taken = 1'b1;
      SEQ_JUMP_IF:  taken = cond_hit;
      SEQ_JUMP_IFN: taken = !cond_hit;
      default:      taken = 1'b0;
    endcase
  end

  // finish step holds while the output register is still occupied
  always_comb begin
    if (ctl.emit && !cond.out_free) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + pc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tdpt_datapath.sv */
// datapath: operand, trial divisor, running square, bit-serial remainder, output register
`default_nettype none
module tdpt_datapath
  import tdpt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  ctl_t                          ctl,
  input  logic                          in_valid,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          out_ready,
  output cond_t                         cond,
  output logic                          out_valid,
  output logic                          is_prime
);

  localparam int W = VALUE_WIDTH;

  logic [W-1:0]     v;
  logic [W-1:0]     d;
  logic [W:0]       sq;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvd;
  logic [CNT_W-1:0] cnt;
  logic             verdict;

  logic             in_fire;
  logic [W:0]       trial;
  logic             fits;
  logic             emit_now;

  assign in_fire  = in_valid && ctl.accept;
  assign trial    = {rem, dvd[W-1]};
  assign fits     = trial >= {1'b0, d};
  assign emit_now = ctl.emit && cond.out_free;

  always_comb begin
    cond.start    = in_valid;
    cond.le1      = v[W-1] || (v[W-1:1] == '0);
    cond.lt4      = v[W-1:2] == '0;
    cond.even     = !v[0];
    cond.sq_gt    = sq > {1'b0, v};
    cond.div_more = cnt != CNT_W'(1);
    cond.rem_zero = rem == '0;
    cond.out_free = !out_valid || out_ready;
  end

  // operand, divisor and square registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      v  <= value;
      d  <= W'(3);
      sq <= (W + 1)'(9);
    end else if (ctl.inc_d) begin
      // (d+2)^2 = d^2 + 4d + 4
      d  <= d + W'(2);
      sq <= sq + ((W + 1)'(d) << 2) + (W + 1)'(4);
    end
  end

  // restoring remainder, one dividend bit per step
  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      rem <= '0;
      dvd <= v;
      cnt <= CNT_W'(W);
    end else if (ctl.div_step) begin
      rem <= fits ? W'(trial - {1'b0, d}) : trial[W-1:0];
      dvd <= dvd << 1;
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.set_res) begin
      verdict <= ctl.res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      is_prime <= verdict;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/trial_division_prime_test.sv */
// top level: trial division primality test over a microcoded sequencer and datapath
`default_nettype none
// Takes one signed 32-bit word on value and returns one bit on is_prime: 1 when
// the value is prime, 0 otherwise (negative values, 0 and 1 are not prime). Both
// channels are valid/ready. One word is worked on at a time: in_ready is high only
// while the sequencer sits in its wait step, and the verdict goes into an output
// register, so a new word can be taken while the previous verdict is still waiting.
// Most of the work is in the bit-serial remainder unit, one dividend bit per cycle.
// Negative values, 0 and 1 are judged not prime by the first test step, 2 and 3
// are judged prime by the next, and even numbers are judged not prime after that.
// An odd value runs a full remainder, a zero test and a divisor step for each odd
// divisor from 3 upward tried up to its square root, so a large prime near 2^31
// tries about 23,000 divisors. It then returns to wait for the next word.
module trial_division_prime_test
  import tdpt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          is_prime
);

  `include "assert_macros.svh"

  ctl_t  ctl;
  cond_t cond;

  // control: step counter walking the microprogram
  tdpt_sequencer u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .ctl  (ctl)
  );

  // datapath: divisor, square, remainder and output verdict
  tdpt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .value     (value),
    .out_ready (out_ready),
    .cond      (cond),
    .out_valid (out_valid),
    .is_prime  (is_prime)
  );

  // only the wait step takes a word
  assign in_ready = ctl.accept;

  // a taken word always moves the sequencer out of its wait step
  `AST_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready,
            "sequencer stayed in wait step after accepting a word")
  // a fresh verdict appears only as the sequencer returns to wait
  `AST_SAME(a_emit_returns_to_wait, clk, rst, $rose(out_valid), in_ready,
            "verdict emitted while a word is still in progress")
  // no divide step runs while the block advertises it is free
  `AST_SAME(a_no_div_when_ready, clk, rst, ctl.div_step, !in_ready,
            "remainder step active in wait step")

endmodule
`default_nettype wire

/* dv/tb_trial_division_prime_test.sv */
// testbench for the trial division prime test: directed corners, random words, verdict scoreboard
`default_nettype none
module tb_trial_division_prime_test;
  import tdpt_pkg::*;

  // one odd value runs a full bit-serial remainder for each odd divisor tried;
  // the largest prime in the field tries about 23,000 divisors. random words are
  // held to a small search of at most TRY_BUDGET odd divisors
  localparam int MAX_CYCLES      = 6_000_000;
  localparam int RANDOM_WORDS    = 100;
  localparam int TRY_BUDGET      = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;

  typedef logic [VALUE_WIDTH-1:0] word_t;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  // expected verdicts in acceptance order
  class prime_scoreboard;
    bit verdict_q[$];
    int errors;

    // sign bit set, 0 and 1 are not prime; 2 and 3 are; then 2 and odd divisors
    // while d * d <= n. tries counts the odd divisors looked at
    static function bit prime_verdict(word_t v, output int tries);
      longint unsigned n;
      longint unsigned d;
      tries = 0;
      n = 64'(v);
      if (v[VALUE_WIDTH-1]) return 1'b0;
      if (n < 2) return 1'b0;
      if (n < 4) return 1'b1;
      if (n % 2 == 0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
        tries++;
        if (n % d == 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(word_t v);
      int tries;
      verdict_q.push_back(prime_verdict(v, tries));
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: is_prime with no word pending: expected none, actual %b", $time, got);
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: is_prime mismatch: expected %b, actual %b", $time, want, got);
      end
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  word_t       value;
  logic        out_valid;
  logic        out_ready;
  logic        is_prime;
  int unsigned cycle_count = 0;

  prime_scoreboard sb = new;

  // corners: sign extremes, 0..5, prime squares on the d * d == n boundary,
  // small composites, large even and odd words, largest prime in the field last
  word_t corner_words[$] = '{
    32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
    32'd7, 32'd9, 32'd15, 32'd25, 32'd49, 32'd97, 32'd121, 32'd1018081,
    32'd65521, 32'd65535, 32'h4000_0000, 32'd2147483645, 32'd2147483646,
    32'd2147483647
  };

  trial_division_prime_test uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_prime  (is_prime)
  );

  always #5 clk = ~clk;

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: every accepted verdict is checked against the oldest expected one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(is_prime);
  end

  // receiver: long hold-off first so the block fills and stalls its input,
  // then random segments of stall patterns
  initial begin
    rx_mode_t mode;
    int       seg;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(16, 160);
      repeat (seg) begin
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
          RX_TOGGLE: out_ready <= ~out_ready;
          default:   out_ready <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // hold the word until accepted, then log its verdict
  task automatic offer_word(word_t v);
    value    <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_word(v);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      value    <= word_t'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // sender pause until every verdict has come back
  task automatic wait_verdicts_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // negatives, tiny and small values, and full-width words mostly odd;
  // redrawn when the divisor search would run long
  function automatic word_t pick_random_value();
    word_t v;
    int    tries;
    int    kind;
    do begin
      kind = $urandom_range(0, 9);
      if (kind < 2) v = word_t'({$urandom, $urandom}) | (word_t'(1) << (VALUE_WIDTH - 1));
      else if (kind == 2) v = word_t'($urandom_range(0, 12));
      else if (kind < 6) v = word_t'($urandom_range(0, 20000));
      else begin
        v = word_t'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
      end
      void'(prime_scoreboard::prime_verdict(v, tries));
    end while (tries > TRY_BUDGET);
    return v;
  endfunction

  initial begin
    int burst;
    int gap;
    int sent;
    in_valid <= 1'b0;
    value    <= '0;
    do @(posedge clk); while (rst);

    // corners, the first few back to back while the receiver holds off
    foreach (corner_words[i]) begin
      offer_word(corner_words[i]);
      if (i > 3) idle_for($urandom_range(0, 2));
    end
    wait_verdicts_drained();

    // random words in bursts with random gaps
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < RANDOM_WORDS; k++) begin
        offer_word(pick_random_value());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      idle_for(gap);
      if ($urandom_range(0, 29) == 0) wait_verdicts_drained();
    end

    wait_verdicts_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
